/* rtl/bpe_pkg.sv */
package bpe_pkg;

    // Input request layout on s_tdata, lowest bit first
    localparam int unsigned S_TDATA_W  = 192;
    localparam int unsigned DEG_LSB    = 0;
    localparam int unsigned CNT_LSB    = 4;
    localparam int unsigned T_LSB      = 12;
    localparam int unsigned CA_LSB     = 29;
    localparam int unsigned CB_LSB     = 61;
    localparam int unsigned CC_LSB     = 93;
    localparam int unsigned CD_LSB     = 125;
    localparam int unsigned CL_LSB     = 157;

    localparam int unsigned DEG_W      = 4;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned T_W        = 17;
    localparam int unsigned PT_W       = 32;

    // Weights all carry 48 fraction bits and sum to one
    localparam int unsigned W_W        = 49;
    localparam int unsigned W_FRAC     = 48;
    localparam int unsigned W_LO_W     = 24;
    localparam int unsigned ACC_W      = 81;

    localparam int unsigned STG_NUM    = 9;

    localparam logic [T_W-1:0]   T_ONE    = 17'h10000;
    localparam logic [DEG_W-1:0] DEG_QUAD = 4'd2;
    localparam logic [DEG_W-1:0] DEG_CUB  = 4'd3;
    localparam logic [CNT_W-1:0] CNT_LIN_MIN  = 8'd2;
    localparam logic [CNT_W-1:0] CNT_QUAD_MIN = 8'd3;
    localparam logic [CNT_W-1:0] CNT_CUB_MIN  = 8'd4;

    typedef enum logic [1:0] {
        MODE_LIN,
        MODE_QUAD,
        MODE_CUB
    } mode_t;

endpackage

/* rtl/bezier_point_evaluator_unit.sv */
// Channel  | Direction | Payload
// s_       | in        | tdata: curve_degree, point_count, param_t, ctrl_a..ctrl_d, ctrl_last
// m_       | out       | tdata: coord_out; tuser: is_default
//
// One request per cycle sustained while m_tready does not stall the output.
// Nine register stages: clamp/decode, t powers, cubic powers, weight select,
// split partial products, term sums, pair sums, total, shift and saturate.
// Reset clears only the stage valid bits; payload registers hold garbage.
// Each stage holds when the one after it is full and not moving; empty
// stages close up, so input is taken while a result waits if any bubble exists.
module bezier_point_evaluator_unit
    import bpe_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // curve_degree[3:0], point_count[11:4], param_t[28:12], ctrl_a[60:29],
    // ctrl_b[92:61], ctrl_c[124:93], ctrl_d[156:125], ctrl_last[188:157], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // coord_out[31:0]
    output logic [PT_W-1:0]      m_tdata,
    // is_default[0]
    output logic [0:0]           m_tuser
);

    localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam logic signed [PT_W:0] SAT_MAX = (33'sd1 <<< (SAT_W - 1)) - 33'sd1;
    localparam logic signed [PT_W:0] SAT_MIN = -(33'sd1 <<< (SAT_W - 1));
    localparam logic [W_W+1:0] W_SUM_ONE = 51'd1 << W_FRAC;

    // handshake chain
    logic [STG_NUM:1] vld_reg, vld_next, rdy;
    logic [STG_NUM:1] dflt_reg, dflt_next;
    logic             dflt_in;

    always_comb begin
        rdy[STG_NUM] = !vld_reg[STG_NUM] || m_tready;
        for (int k = STG_NUM - 1; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next  = vld_reg;
        dflt_next = dflt_reg;
        if (rdy[1]) begin
            vld_next[1]  = s_tvalid;
            dflt_next[1] = dflt_in;
        end
        for (int k = 2; k <= STG_NUM; k++) begin
            if (rdy[k]) begin
                vld_next[k]  = vld_reg[k-1];
                dflt_next[k] = dflt_reg[k-1];
            end
        end
    end

    assign s_tready = rdy[1];
    assign m_tvalid = vld_reg[STG_NUM];

    // stage 1: clamp t, decode mode, pick control values
    logic [DEG_W-1:0] deg_in;
    logic [CNT_W-1:0] cnt_in;
    logic [T_W-1:0]   t_in, t1_next, mt1_next;
    mode_t            mode1_next;
    logic signed [PT_W-1:0] p1_next [4];

    logic [T_W-1:0] t1_reg, mt1_reg;
    mode_t          mode1_reg;
    logic signed [PT_W-1:0] p1_reg [4];

    always_comb begin
        deg_in   = s_tdata[DEG_LSB +: DEG_W];
        cnt_in   = s_tdata[CNT_LSB +: CNT_W];
        t_in     = s_tdata[T_LSB +: T_W];
        t1_next  = (t_in > T_ONE) ? T_ONE : t_in;
        mt1_next = T_ONE - t1_next;
        dflt_in  = (cnt_in < CNT_LIN_MIN)
            || ((deg_in == DEG_QUAD) && (cnt_in < CNT_QUAD_MIN))
            || ((deg_in == DEG_CUB) && (cnt_in < CNT_CUB_MIN));
        case (deg_in)
            DEG_QUAD: mode1_next = MODE_QUAD;
            DEG_CUB:  mode1_next = MODE_CUB;
            default:  mode1_next = MODE_LIN;
        endcase
        p1_next[0] = $signed(s_tdata[CA_LSB +: PT_W]);
        p1_next[1] = (mode1_next == MODE_LIN) ? $signed(s_tdata[CL_LSB +: PT_W])
                                              : $signed(s_tdata[CB_LSB +: PT_W]);
        p1_next[2] = $signed(s_tdata[CC_LSB +: PT_W]);
        p1_next[3] = $signed(s_tdata[CD_LSB +: PT_W]);
    end

    // stage 2: squares and cross product
    logic [2*T_W-1:0] mt2_next, t2_next, mtt_next;
    logic [2*T_W-1:0] mt2_reg, t2_reg, mtt_reg;
    logic [T_W-1:0]   t2s_reg, mt2s_reg;
    mode_t            mode2_reg;
    logic signed [PT_W-1:0] p2_reg [4];

    assign mt2_next = mt1_reg * mt1_reg;
    assign t2_next  = t1_reg * t1_reg;
    assign mtt_next = mt1_reg * t1_reg;

    // stage 3: cubes
    logic [3*T_W-1:0] mt3_next, mt2t_next, mtt2_next, t3_next;
    logic [W_W-1:0]   mt3_reg, mt2t_reg, mtt2_reg, t3_reg;
    logic [2*T_W-1:0] mt2_3_reg, t2_3_reg, mtt_3_reg;
    logic [T_W-1:0]   t3s_reg, mt3s_reg;
    mode_t            mode3_reg;
    logic signed [PT_W-1:0] p3_reg [4];

    assign mt3_next  = mt2_reg * mt2s_reg;
    assign mt2t_next = mt2_reg * t2s_reg;
    assign mtt2_next = mtt_reg * t2s_reg;
    assign t3_next   = t2_reg * t2s_reg;

    // stage 4: Bernstein weights scaled to 48 fraction bits
    logic [W_W-1:0] w4_next [4];
    logic [W_W-1:0] w4_reg [4];
    logic [W_W:0]   mt2t_x3, mtt2_x3;
    logic signed [PT_W-1:0] p4_reg [4];

    always_comb begin
        mt2t_x3 = {1'b0, mt2t_reg} + {mt2t_reg, 1'b0};
        mtt2_x3 = {1'b0, mtt2_reg} + {mtt2_reg, 1'b0};
        case (mode3_reg)
            MODE_QUAD: begin
                w4_next[0] = {mt2_3_reg[32:0], 16'b0};
                w4_next[1] = {mtt_3_reg[31:0], 17'b0};
                w4_next[2] = {t2_3_reg[32:0], 16'b0};
                w4_next[3] = '0;
            end
            MODE_CUB: begin
                w4_next[0] = mt3_reg;
                w4_next[1] = mt2t_x3[W_W-1:0];
                w4_next[2] = mtt2_x3[W_W-1:0];
                w4_next[3] = t3_reg;
            end
            default: begin
                w4_next[0] = {mt3s_reg, 32'b0};
                w4_next[1] = {t3s_reg, 32'b0};
                w4_next[2] = '0;
                w4_next[3] = '0;
            end
        endcase
    end

    // stage 5: weight split into low 24 and high 25 bits, two products per term
    logic signed [56:0] pl5_next [4];
    logic signed [57:0] ph5_next [4];
    logic signed [56:0] pl5_reg [4];
    logic signed [57:0] ph5_reg [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pl5_next[i] = p4_reg[i] * $signed({1'b0, w4_reg[i][W_LO_W-1:0]});
            ph5_next[i] = p4_reg[i] * $signed({1'b0, w4_reg[i][W_W-1:W_LO_W]});
        end
    end

    // stage 6: recombine each term
    logic signed [ACC_W-1:0] tm6_next [4];
    logic signed [ACC_W-1:0] tm6_reg [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            tm6_next[i] = ({{23{ph5_reg[i][57]}}, ph5_reg[i]} <<< W_LO_W)
                        + {{24{pl5_reg[i][56]}}, pl5_reg[i]};
        end
    end

    // stages 7 and 8: adder tree
    logic signed [ACC_W-1:0] pr7_reg [2];
    logic signed [ACC_W-1:0] sum8_reg;

    // stage 9: floor by 2^48, saturate, force zero on default
    logic signed [PT_W:0]  v9;
    logic [PT_W-1:0]       coord_next, coord_reg;

    always_comb begin
        v9 = sum8_reg[ACC_W-1:W_FRAC];
        if (dflt_reg[STG_NUM-1]) begin
            coord_next = '0;
        end else if (v9 > SAT_MAX) begin
            coord_next = SAT_MAX[PT_W-1:0];
        end else if (v9 < SAT_MIN) begin
            coord_next = SAT_MIN[PT_W-1:0];
        end else begin
            coord_next = v9[PT_W-1:0];
        end
    end

    assign m_tdata    = coord_reg;
    assign m_tuser[0] = dflt_reg[STG_NUM];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        dflt_reg <= dflt_next;
        if (rdy[1]) begin
            t1_reg    <= t1_next;
            mt1_reg   <= mt1_next;
            mode1_reg <= mode1_next;
            p1_reg    <= p1_next;
        end
        if (rdy[2]) begin
            mt2_reg   <= mt2_next;
            t2_reg    <= t2_next;
            mtt_reg   <= mtt_next;
            t2s_reg   <= t1_reg;
            mt2s_reg  <= mt1_reg;
            mode2_reg <= mode1_reg;
            p2_reg    <= p1_reg;
        end
        if (rdy[3]) begin
            mt3_reg   <= mt3_next[W_W-1:0];
            mt2t_reg  <= mt2t_next[W_W-1:0];
            mtt2_reg  <= mtt2_next[W_W-1:0];
            t3_reg    <= t3_next[W_W-1:0];
            mt2_3_reg <= mt2_reg;
            t2_3_reg  <= t2_reg;
            mtt_3_reg <= mtt_reg;
            t3s_reg   <= t2s_reg;
            mt3s_reg  <= mt2s_reg;
            mode3_reg <= mode2_reg;
            p3_reg    <= p2_reg;
        end
        if (rdy[4]) begin
            w4_reg <= w4_next;
            p4_reg <= p3_reg;
        end
        if (rdy[5]) begin
            pl5_reg <= pl5_next;
            ph5_reg <= ph5_next;
        end
        if (rdy[6]) begin
            tm6_reg <= tm6_next;
        end
        if (rdy[7]) begin
            pr7_reg[0] <= tm6_reg[0] + tm6_reg[1];
            pr7_reg[1] <= tm6_reg[2] + tm6_reg[3];
        end
        if (rdy[8]) begin
            sum8_reg <= pr7_reg[0] + pr7_reg[1];
        end
        if (rdy[9]) begin
            coord_reg <= coord_next;
        end
    end

    // a default result always carries zero
    a_dflt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("default result with nonzero coordinate");

    // weights of every mode form a partition of one
    a_w_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[4] |-> ({2'b0, w4_reg[0]} + {2'b0, w4_reg[1]}
                       + {2'b0, w4_reg[2]} + {2'b0, w4_reg[3]}) == W_SUM_ONE)
        else $error("weights do not sum to one");

    // with the output stage empty, every stage can move
    a_rdy_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

/* tb/sv/bezier_point_evaluator_unit_tb.sv */
module bezier_point_evaluator_unit_tb
    import bpe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W     = 32;
    localparam int QUIET_LIMIT = 2000;
    localparam int RAND_PER_PHASE = 258;

    typedef struct packed {
        logic [DEG_W-1:0] curve_degree;
        logic [CNT_W-1:0] point_count;
        logic [T_W-1:0]   param_t;
        logic [PT_W-1:0]  ctrl_a;
        logic [PT_W-1:0]  ctrl_b;
        logic [PT_W-1:0]  ctrl_c;
        logic [PT_W-1:0]  ctrl_d;
        logic [PT_W-1:0]  ctrl_last;
    } point_req_t;

    typedef struct packed {
        logic [PT_W-1:0] coord_out;
        logic            is_default;
    } axis_result_t;

    typedef struct packed {
        point_req_t   req;
        logic         typed;
        axis_result_t want;
    } curve_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [PT_W-1:0]      m_tdata;
    logic [0:0]           m_tuser;

    axis_result_t expected_points[$];
    curve_row_t   curve_rows[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int requests_sent  = 0;
    int points_checked = 0;
    int defaults_seen  = 0;
    int quiet_cycles   = 0;

    bezier_point_evaluator_unit #(
        .COORD_WIDTH(COORD_W)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [S_TDATA_W-1:0] pack_request(input point_req_t r);
        logic [S_TDATA_W-1:0] v;
        v = '0;
        v[DEG_LSB +: DEG_W] = r.curve_degree;
        v[CNT_LSB +: CNT_W] = r.point_count;
        v[T_LSB +: T_W]     = r.param_t;
        v[CA_LSB +: PT_W]   = r.ctrl_a;
        v[CB_LSB +: PT_W]   = r.ctrl_b;
        v[CC_LSB +: PT_W]   = r.ctrl_c;
        v[CD_LSB +: PT_W]   = r.ctrl_d;
        v[CL_LSB +: PT_W]   = r.ctrl_last;
        return v;
    endfunction

    // Exact product of an unsigned weight and a signed Q16.16 control value
    function automatic logic signed [95:0] weigh(input logic [63:0] w, input logic [31:0] p);
        logic signed [95:0] ws;
        logic signed [95:0] ps;
        ws = {32'd0, w};
        ps = {{64{p[31]}}, p};
        return ws * ps;
    endfunction

    function automatic axis_result_t eval_axis(input point_req_t r);
        axis_result_t       res;
        mode_t              mode;
        logic [63:0]        t;
        logic [63:0]        mt;
        logic signed [95:0] acc;
        logic signed [95:0] top;
        int                 fbits;
        t = (r.param_t > T_ONE) ? 64'(T_ONE) : 64'(r.param_t);
        mt = 64'(T_ONE) - t;
        res = '0;
        if (r.point_count < CNT_LIN_MIN
            || (r.curve_degree == DEG_QUAD && r.point_count < CNT_QUAD_MIN)
            || (r.curve_degree == DEG_CUB && r.point_count < CNT_CUB_MIN)) begin
            res.is_default = 1'b1;
            return res;
        end
        if (r.curve_degree == DEG_QUAD)
            mode = MODE_QUAD;
        else if (r.curve_degree == DEG_CUB)
            mode = MODE_CUB;
        else
            mode = MODE_LIN;
        case (mode)
            MODE_QUAD: begin
                fbits = 32;
                acc = weigh(mt * mt, r.ctrl_a) + weigh(2 * mt * t, r.ctrl_b)
                    + weigh(t * t, r.ctrl_c);
            end
            MODE_CUB: begin
                fbits = 48;
                acc = weigh(mt * mt * mt, r.ctrl_a) + weigh(3 * mt * mt * t, r.ctrl_b)
                    + weigh(3 * mt * t * t, r.ctrl_c) + weigh(t * t * t, r.ctrl_d);
            end
            default: begin
                fbits = 16;
                acc = weigh(mt, r.ctrl_a) + weigh(t, r.ctrl_last);
            end
        endcase
        // floor division by the weight scale
        acc = acc >>> fbits;
        top = 96'sd1 <<< (COORD_W - 1);
        if (acc > top - 1)
            acc = top - 1;
        if (acc < -top)
            acc = -top;
        res.coord_out = acc[PT_W-1:0];
        return res;
    endfunction

    function automatic logic [PT_W-1:0] rand_ctrl();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 262143)) - 32'd131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic point_req_t rand_request();
        point_req_t r;
        case ($urandom_range(3))
            0: r.curve_degree = DEG_QUAD;
            1: r.curve_degree = DEG_CUB;
            default: r.curve_degree = DEG_W'($urandom_range(0, 15));
        endcase
        if ($urandom_range(9) == 0)
            r.point_count = CNT_W'($urandom_range(0, 3));
        else
            r.point_count = CNT_W'($urandom_range(4, 255));
        case ($urandom_range(9))
            0: r.param_t = '0;
            1: r.param_t = T_ONE;
            2: r.param_t = T_W'($urandom_range(65537, 131071));
            default: r.param_t = T_W'($urandom_range(0, 65536));
        endcase
        r.ctrl_a    = rand_ctrl();
        r.ctrl_b    = rand_ctrl();
        r.ctrl_c    = rand_ctrl();
        r.ctrl_d    = rand_ctrl();
        r.ctrl_last = rand_ctrl();
        return r;
    endfunction

    task automatic add_row(input int deg, input int cnt, input int t,
                           input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] d,
                           input logic [31:0] l, input logic typed,
                           input logic [31:0] coord, input logic dflt);
        curve_row_t row;
        row.req = '{DEG_W'(deg), CNT_W'(cnt), T_W'(t), a, b, c, d, l};
        row.typed = typed;
        row.want = '{coord, dflt};
        curve_rows.insert(curve_rows.size(), row);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] %s mismatch: got %08h, want %08h", $realtime, what, got, want);
    endtask

    task automatic send_request(input point_req_t r, input logic typed,
                                input axis_result_t want);
        s_tdata <= pack_request(r);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_points.insert(expected_points.size(), typed ? want : eval_axis(r));
        requests_sent++;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        axis_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, '0);
            end else begin
                want = expected_points.pop_front();
                points_checked++;
                if (m_tuser[0])
                    defaults_seen++;
                if (m_tdata !== want.coord_out)
                    report_mismatch("coord_out", m_tdata, want.coord_out);
                if (m_tuser[0] !== want.is_default)
                    report_mismatch("is_default", 32'(m_tuser), 32'(want.is_default));
            end
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no progress for %0d cycles", $realtime, QUIET_LIMIT);
            $display("** bezier_point_evaluator_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int send_pct[4];
        int recv_pct[4];
        int directed;
        send_pct = '{0, 61, 0, 26};
        recv_pct = '{0, 0, 61, 26};

        // too few points, any degree
        add_row(3, 0, 32768, $urandom, $urandom, $urandom, $urandom, $urandom, 1, 0, 1);
        add_row(0, 1, 0, $urandom, $urandom, $urandom, $urandom, $urandom, 1, 0, 1);
        add_row(15, 1, 65536, $urandom, $urandom, $urandom, $urandom, $urandom, 1, 0, 1);
        add_row(2, 2, 1000, $urandom, $urandom, $urandom, $urandom, $urandom, 1, 0, 1);
        add_row(3, 3, 50000, $urandom, $urandom, $urandom, $urandom, $urandom, 1, 0, 1);
        add_row(3, 2, 50000, $urandom, $urandom, $urandom, $urandom, $urandom, 1, 0, 1);
        // endpoints pick one control value exactly
        add_row(2, 3, 0, 32'h1234_5678, $urandom, $urandom, $urandom, $urandom,
                1, 32'h1234_5678, 0);
        add_row(3, 4, 65536, $urandom, $urandom, $urandom, 32'h89ab_cdef, $urandom,
                1, 32'h89ab_cdef, 0);
        add_row(0, 2, 65536, $urandom, $urandom, $urandom, $urandom, 32'hfedc_ba98,
                1, 32'hfedc_ba98, 0);
        add_row(15, 255, 0, 32'h8000_0001, $urandom, $urandom, $urandom, $urandom,
                1, 32'h8000_0001, 0);
        // t above one clamps to one
        add_row(1, 200, 131071, $urandom, $urandom, $urandom, $urandom, 32'h0001_0000,
                1, 32'h0001_0000, 0);
        add_row(3, 255, 70000, $urandom, $urandom, $urandom, 32'hffff_0000, $urandom,
                1, 32'hffff_0000, 0);
        add_row(2, 3, 100000, $urandom, $urandom, 32'h7fff_ffff, $urandom, $urandom,
                1, 32'h7fff_ffff, 0);
        // equal control values give that value back; the rows after those are checked against eval_axis
        add_row(3, 4, 23456, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                $urandom, 1, 32'h8000_0000, 0);
        add_row(2, 255, 12345, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, $urandom,
                $urandom, 1, 32'h7fff_ffff, 0);
        add_row(0, 2, 40000, 32'h8000_0000, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0);
        add_row(3, 4, 32768, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                $urandom, 0, 0, 0);
        add_row(2, 3, 1, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
        add_row(3, 4, 65535, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
        add_row(7, 3, 21845, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
        add_row(14, 255, 98304, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
        add_row(3, 255, 32768, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001,
                $urandom, 0, 0, 0);
        directed = curve_rows.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (curve_rows[i])
            send_request(curve_rows[i].req, curve_rows[i].typed, curve_rows[i].want);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            repeat (RAND_PER_PHASE)
                send_request(rand_request(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (expected_points.size() != 0)
            @(posedge aclk);
        repeat (3 * STG_NUM) @(posedge aclk);

        $display("Sent %0d requests (%0d directed, rest random) under four idle/stall mixes.",
                 requests_sent, directed);
        $display("Checked %0d points, %0d of them defaulted; %0d mismatches.",
                 points_checked, defaults_seen, mismatches);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("** bezier_point_evaluator_unit: PASSED **");
        else
            $display("** bezier_point_evaluator_unit: FAILED **");
        $finish;
    end

endmodule
